// ===== hw/rtl/cfr_pkg.sv =====
// Shared types, codes and command byte values for the command frame receiver.
// Depends on nothing; the deframer, the command executor and the top level refer to it by scoped name.
package cfr_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_ZERO_LEN = 2'd2,
        ST_LINK_LOST = 2'd3
    } t_status;

    // Motor direction codes.
    typedef enum logic [1:0] {
        MOTOR_STOP = 2'd0,
        MOTOR_UP   = 2'd1,
        MOTOR_DOWN = 2'd2
    } t_motor;

    // Action codes reported for an accepted frame.
    typedef enum logic [4:0] {
        ACT_NONE       = 5'd0,
        ACT_RESET      = 5'd1,
        ACT_SHOW       = 5'd2,
        ACT_LED_ON     = 5'd3,
        ACT_LED_OFF    = 5'd4,
        ACT_STREAM_ON  = 5'd5,
        ACT_STREAM_OFF = 5'd6,
        ACT_ZERO_0     = 5'd7,
        ACT_ZERO_1     = 5'd8,
        ACT_CAL_0      = 5'd9,
        ACT_CAL_1      = 5'd10,
        ACT_MOTOR_UP   = 5'd11,
        ACT_MOTOR_DOWN = 5'd12,
        ACT_MOTOR_STOP = 5'd13,
        ACT_TEST       = 5'd14,
        ACT_ALARM      = 5'd15,
        ACT_PLAY       = 5'd16
    } t_action;

    // Command bytes (ASCII letters).
    localparam logic [7:0] CMD_RESET      = 8'h52; // R
    localparam logic [7:0] CMD_SHOW       = 8'h44; // D
    localparam logic [7:0] CMD_LED_ON     = 8'h4C; // L
    localparam logic [7:0] CMD_LED_OFF    = 8'h6C; // l
    localparam logic [7:0] CMD_STREAM_ON  = 8'h53; // S
    localparam logic [7:0] CMD_STREAM_OFF = 8'h73; // s
    localparam logic [7:0] CMD_ZERO_0     = 8'h5A; // Z
    localparam logic [7:0] CMD_ZERO_1     = 8'h7A; // z
    localparam logic [7:0] CMD_CAL_0      = 8'h43; // C
    localparam logic [7:0] CMD_CAL_1      = 8'h63; // c
    localparam logic [7:0] CMD_MOTOR_UP   = 8'h4D; // M
    localparam logic [7:0] CMD_MOTOR_DOWN = 8'h6D; // m
    localparam logic [7:0] CMD_MOTOR_STOP = 8'h78; // x
    localparam logic [7:0] CMD_TEST       = 8'h54; // T
    localparam logic [7:0] CMD_ALARM      = 8'h41; // A
    localparam logic [7:0] CMD_PLAY       = 8'h50; // P

    localparam logic [7:0] HEADER_RESET = 8'd170;
    localparam int         WINDOW_DEPTH = 4;

    // Frame end event from the deframer to the command executor.
    typedef struct packed {
        logic      done;
        t_status   status;
        logic [7:0] cmd;
    } t_frame_evt;

    // One result item.
    typedef struct packed {
        logic      valid;
        t_status   status;
        logic [7:0] command_code;
        t_action   action;
        logic      led_on;
        logic      streaming;
        t_motor    motor_dir;
        logic      motor_ready;
    } t_result;

endpackage

// ===== hw/rtl/cfr_in_if.sv =====
// Request channel of the command frame receiver: valid, ready and one input item.
// Depends on nothing.
interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    logic       link_up;

    modport source (output valid, output mode, output rx_byte, output link_up, input ready);
    modport sink   (input valid, input mode, input rx_byte, input link_up, output ready);
endinterface

// ===== hw/rtl/cfr_out_if.sv =====
// Result channel of the command frame receiver: valid, ready and one result item.
// Depends on nothing.
interface cfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] command_code;
    logic [4:0] action;
    logic       led_on;
    logic       streaming;
    logic [1:0] motor_dir;
    logic       motor_ready;

    modport source (output valid, output status, output command_code, output action,
                    output led_on, output streaming, output motor_dir, output motor_ready,
                    input ready);
    modport sink   (input valid, input status, input command_code, input action,
                    input led_on, input streaming, input motor_dir, input motor_ready,
                    output ready);
endinterface

// ===== hw/rtl/cfr_cfg_if.sv =====
// Configuration write channel: valid, ready and the header byte to be written.
// Depends on nothing.
interface cfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cfr_deframer.sv =====
// Header hunt, length count and checksum check for received bytes.
// Depends on cfr_pkg for the frame event type and status codes.
module cfr_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_rx_byte,
    input  logic [7:0]          i_header,
    output cfr_pkg::t_frame_evt o_evt
);

    logic [cfr_pkg::WINDOW_DEPTH-1:0][7:0] r_window, n_window;
    logic       r_in_payload, n_in_payload;
    logic [7:0] r_frame_length, n_frame_length;
    logic [7:0] r_bytes_seen, n_bytes_seen;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_cmd, n_cmd;
    logic [8:0] bytes_next;

    assign bytes_next = {1'b0, r_bytes_seen} + 9'd1;

    always_comb begin
        n_window       = r_window;
        n_in_payload   = r_in_payload;
        n_frame_length = r_frame_length;
        n_bytes_seen   = r_bytes_seen;
        n_sum          = r_sum;
        n_cmd          = r_cmd;
        o_evt.done     = 1'b0;
        o_evt.status   = cfr_pkg::ST_ACCEPTED;
        o_evt.cmd      = r_cmd;
        if (r_in_payload) begin
            if (bytes_next >= {1'b0, r_frame_length}) begin
                // Last byte of the frame carries the inverted sum.
                o_evt.done   = 1'b1;
                o_evt.status = (i_rx_byte == ~r_sum) ? cfr_pkg::ST_ACCEPTED
                                                     : cfr_pkg::ST_BAD_SUM;
                n_window     = '0;
                n_in_payload = 1'b0;
                n_bytes_seen = 8'd0;
            end else begin
                n_sum        = r_sum + i_rx_byte;
                n_bytes_seen = bytes_next[7:0];
            end
        end else begin
            n_window = {r_window[2:0], i_rx_byte};
            if (r_window[2] == i_header && r_window[1] == i_header) begin
                n_cmd          = r_window[0];
                n_frame_length = i_rx_byte;
                n_sum          = r_window[0] + i_rx_byte;
                n_bytes_seen   = 8'd0;
                if (i_rx_byte == 8'd0) begin
                    n_window     = '0;
                    o_evt.done   = 1'b1;
                    o_evt.status = cfr_pkg::ST_ZERO_LEN;
                    o_evt.cmd    = r_window[0];
                end else begin
                    n_in_payload = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window       <= '0;
            r_in_payload   <= 1'b0;
            r_frame_length <= 8'd0;
            r_bytes_seen   <= 8'd0;
            r_sum          <= 8'd0;
            r_cmd          <= 8'd0;
        end else if (i_en) begin
            r_window       <= n_window;
            r_in_payload   <= n_in_payload;
            r_frame_length <= n_frame_length;
            r_bytes_seen   <= n_bytes_seen;
            r_sum          <= n_sum;
            r_cmd          <= n_cmd;
        end
    end

    // The count never reaches the length while a payload is open.
    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_bytes_seen < r_frame_length))
        else $error("payload count reached frame length");

    // Outside a payload the count rests at zero.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_payload |-> (r_bytes_seen == 8'd0))
        else $error("byte count not cleared while hunting");

    // Any frame end leaves an empty window and hunting mode behind.
    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_evt.done) |=> (r_window == '0 && !r_in_payload))
        else $error("window not cleared after frame end");

endmodule

// ===== hw/rtl/cfr_cmd_exec.sv =====
// Command decode, device flags and link-loss handling; forms the result item.
// Depends on cfr_pkg for the codes, command bytes and the event and result types.
module cfr_cmd_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_frame_en,
    input  cfr_pkg::t_frame_evt i_evt,
    input  logic                i_link_en,
    input  logic                i_link_up,
    output cfr_pkg::t_result    o_result
);

    logic             r_led, n_led;
    logic             r_stream, n_stream;
    cfr_pkg::t_motor  r_motor, n_motor;
    logic             r_ready, n_ready;
    logic             r_link;
    cfr_pkg::t_action act;
    logic             fell;
    logic             frame_end;

    assign fell      = i_link_en && r_link && !i_link_up;
    assign frame_end = i_frame_en && i_evt.done;

    always_comb begin
        n_led    = r_led;
        n_stream = r_stream;
        n_motor  = r_motor;
        n_ready  = r_ready;
        act      = cfr_pkg::ACT_NONE;
        if (frame_end && i_evt.status == cfr_pkg::ST_ACCEPTED) begin
            case (i_evt.cmd)
                cfr_pkg::CMD_RESET:      act = cfr_pkg::ACT_RESET;
                cfr_pkg::CMD_SHOW:       act = r_stream ? cfr_pkg::ACT_NONE
                                                        : cfr_pkg::ACT_SHOW;
                cfr_pkg::CMD_LED_ON: begin
                    n_led = 1'b1;
                    act   = cfr_pkg::ACT_LED_ON;
                end
                cfr_pkg::CMD_LED_OFF: begin
                    n_led = 1'b0;
                    act   = cfr_pkg::ACT_LED_OFF;
                end
                cfr_pkg::CMD_STREAM_ON: begin
                    n_stream = 1'b1;
                    n_ready  = 1'b0;
                    act      = cfr_pkg::ACT_STREAM_ON;
                end
                cfr_pkg::CMD_STREAM_OFF: begin
                    n_stream = 1'b0;
                    n_ready  = 1'b1;
                    act      = cfr_pkg::ACT_STREAM_OFF;
                end
                cfr_pkg::CMD_ZERO_0:     act = cfr_pkg::ACT_ZERO_0;
                cfr_pkg::CMD_ZERO_1:     act = cfr_pkg::ACT_ZERO_1;
                cfr_pkg::CMD_CAL_0:      act = cfr_pkg::ACT_CAL_0;
                cfr_pkg::CMD_CAL_1:      act = cfr_pkg::ACT_CAL_1;
                cfr_pkg::CMD_MOTOR_UP: begin
                    n_motor = cfr_pkg::MOTOR_UP;
                    act     = cfr_pkg::ACT_MOTOR_UP;
                end
                cfr_pkg::CMD_MOTOR_DOWN: begin
                    n_motor = cfr_pkg::MOTOR_DOWN;
                    act     = cfr_pkg::ACT_MOTOR_DOWN;
                end
                cfr_pkg::CMD_MOTOR_STOP: begin
                    n_motor = cfr_pkg::MOTOR_STOP;
                    act     = cfr_pkg::ACT_MOTOR_STOP;
                end
                cfr_pkg::CMD_TEST: begin
                    n_motor = cfr_pkg::MOTOR_STOP;
                    act     = cfr_pkg::ACT_TEST;
                end
                cfr_pkg::CMD_ALARM:      act = cfr_pkg::ACT_ALARM;
                cfr_pkg::CMD_PLAY:       act = cfr_pkg::ACT_PLAY;
                default:                 act = cfr_pkg::ACT_NONE;
            endcase
        end
        if (fell) begin
            n_led    = 1'b0;
            n_stream = 1'b0;
            n_motor  = cfr_pkg::MOTOR_STOP;
        end
    end

    always_comb begin
        o_result.valid        = frame_end || fell;
        o_result.status       = fell ? cfr_pkg::ST_LINK_LOST : i_evt.status;
        o_result.command_code = fell ? 8'd0 : i_evt.cmd;
        o_result.action       = act;
        o_result.led_on       = n_led;
        o_result.streaming    = n_stream;
        o_result.motor_dir    = n_motor;
        o_result.motor_ready  = n_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led    <= 1'b0;
            r_stream <= 1'b0;
            r_motor  <= cfr_pkg::MOTOR_STOP;
            r_ready  <= 1'b0;
            r_link   <= 1'b0;
        end else begin
            r_led    <= n_led;
            r_stream <= n_stream;
            r_motor  <= n_motor;
            r_ready  <= n_ready;
            if (i_link_en) begin
                r_link <= i_link_up;
            end
        end
    end

endmodule

// ===== hw/rtl/command_frame_receiver.sv =====
// Top level of the command frame receiver: input register, deframer, command
// executor and result register. Depends on cfr_pkg and the three channel interfaces.
//
// The block takes one request per clock cycle, each either a received serial byte
// (mode 0) or a sample of the link-connected level (mode 1). Bytes pass through a
// four-byte window; two header bytes in a row followed by a command byte and a
// non-zero length byte open a frame, and the last of the length's worth of bytes
// that follow must be the inverted 8-bit sum of command, length and the bytes in
// between. A frame end yields one result: accepted (with the decoded action and the
// updated LED, streaming, motor and ready flags), bad checksum, or zero length.
// A fall of the link level yields a link-lost result that stops streaming and the
// motor and turns the LED off; other requests yield no result. Throughput is one
// request per cycle while the result register is empty or being collected; a
// request is held in the input register and its result in the result register,
// from which it is presented. Requests are still taken while a result waits to be
// collected, until the input register is also occupied. The header byte is
// written through the configuration channel, which is always ready, and should
// only be written while the block is idle.
module command_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfr_in_if.sink      i_req,
    cfr_out_if.source   o_res,
    cfr_cfg_if.sink     i_cfg
);

    // Input register.
    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;
    logic       r_in_link;

    // Result register.
    logic             r_out_valid;
    cfr_pkg::t_result r_out;

    logic [7:0] r_header;

    logic                advance;
    cfr_pkg::t_frame_evt evt;
    cfr_pkg::t_result    result;

    // The processing stage moves whenever the result register can take its output.
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= cfr_pkg::HEADER_RESET;
        end else if (i_cfg.valid) begin
            r_header <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_mode <= i_req.mode;
            r_in_byte <= i_req.rx_byte;
            r_in_link <= i_req.link_up;
        end
    end

    cfr_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance && !r_in_mode),
        .i_rx_byte (r_in_byte),
        .i_header  (r_header),
        .o_evt     (evt)
    );

    cfr_cmd_exec u_cmd_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame_en (advance && !r_in_mode),
        .i_evt      (evt),
        .i_link_en  (advance && r_in_mode),
        .i_link_up  (r_in_link),
        .o_result   (result)
    );

    // A stage that advances without a result leaves the register empty, since the
    // previous result was either absent or taken in this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out <= result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.command_code = r_out.command_code;
    assign o_res.action       = r_out.action;
    assign o_res.led_on       = r_out.led_on;
    assign o_res.streaming    = r_out.streaming;
    assign o_res.motor_dir    = r_out.motor_dir;
    assign o_res.motor_ready  = r_out.motor_ready;

    // A waiting result is never overwritten by the processing stage.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !advance)
        else $error("result register overwritten while waiting");

    // Only an accepted frame carries an action.
    a_action_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != cfr_pkg::ST_ACCEPTED)
            |-> (r_out.action == cfr_pkg::ACT_NONE))
        else $error("action reported on a rejected frame");

    // A link-lost result always shows the LED off, streaming stopped and motor stopped.
    a_link_lost_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == cfr_pkg::ST_LINK_LOST)
            |-> (!r_out.led_on && !r_out.streaming && r_out.motor_dir == cfr_pkg::MOTOR_STOP))
        else $error("link loss did not clear the device flags");

endmodule
